@@ rtl/sid_pkg.sv @@
// Shared types and constants for the sorted ID set membership unit.
// No dependencies; imported by sid_cmp and sorted_id_set_membership_unit.
`timescale 1ns / 1ps
`default_nettype none

package sid_pkg;

    localparam int ID_W    = 32;
    localparam int COUNT_W = 11;

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_QUERY = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]             action;
        logic signed [ID_W-1:0] id_value;
    } in_item_t;

    typedef struct packed {
        logic               found;
        logic               status;
        logic [COUNT_W-1:0] entry_count;
    } out_item_t;

    // Outcome of comparing the looked-up ID against a table probe
    typedef struct packed {
        logic eq;
        logic lt;   // looked-up ID is below the probe
    } cmp_res_t;

endpackage

`default_nettype wire

@@ rtl/sid_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/sid_cmp.sv @@
// Shared signed compare unit used by every binary search step.
// Depends on sid_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sid_cmp (
    input  wire logic [sid_pkg::ID_W-1:0] key,
    input  wire logic [sid_pkg::ID_W-1:0] probe,
    output sid_pkg::cmp_res_t             res
);

    import sid_pkg::*;

    always_comb
    begin
        res.eq = (key == probe);
        res.lt = ($signed(key) < $signed(probe));
    end

endmodule

`default_nettype wire

@@ rtl/sorted_id_set_membership_unit.sv @@
// Sorted ID set membership unit: sorted ID table with binary-search lookup.
// busy drops in the done cycle, so the next item may be accepted at the edge that
// ends it. One probe per cycle. A query takes p <= ceil(log2(n+1)) probes over n
// held IDs (11 at 1024). A load takes p probes, moves m entries up, each with a read
// and a write state, then writes the ID. Clear, unused actions, empty query and
// full-table load never leave idle. done is a strobe the receiver cannot stall.
// Reset empties the table at once (count to zero); no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module sorted_id_set_membership_unit #(
    parameter int CAPACITY = 1024
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire sid_pkg::in_item_t  cmd,
    output logic                    done,
    output sid_pkg::out_item_t      result
);

    import sid_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_SH_RD,
        S_SH_WR,
        S_INS
    } state_t;

    state_t          state_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   lo_reg;
    logic [CW-1:0]   hi_reg;
    logic [CW-1:0]   mid_reg;
    logic [CW-1:0]   idx_reg;
    logic [1:0]      op_reg;
    logic [ID_W-1:0] id_reg;
    logic            done_reg;
    out_item_t       result_reg;

    logic [CW-1:0]   lo_next;
    logic [CW-1:0]   hi_next;
    logic [CW-1:0]   mid_next;
    logic [CW-1:0]   mid_first;
    logic [CW-1:0]   idx_dec;
    logic [AW-1:0]   rd_addr;
    logic [ID_W-1:0] rd_data;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [ID_W-1:0] wr_data;
    cmp_res_t        cmp;

    function automatic logic [COUNT_W-1:0] fit_count(input logic [CW-1:0] c);
        logic [CW+COUNT_W-1:0] w;
        w = {{COUNT_W{1'b0}}, c};
        return w[COUNT_W-1:0];
    endfunction

    sid_ram #(
        .WIDTH (ID_W),
        .DEPTH (CAPACITY)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    sid_cmp u_cmp (
        .key   (id_reg),
        .probe (rd_data),
        .res   (cmp)
    );

    // Narrow the search window from the probe just read
    always_comb
    begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (op_reg == ACT_LOAD)
        begin
            if (cmp.lt)
                hi_next = mid_reg;
            else
                lo_next = mid_reg + CW'(1);
        end
        else
        begin
            if (cmp.lt)
                hi_next = mid_reg;
            else
                lo_next = mid_reg + CW'(1);
        end
        mid_next  = lo_next + ((hi_next - lo_next) >> 1);
        mid_first = count_reg >> 1;
        idx_dec   = idx_reg - CW'(1);
    end

    always_comb
    begin
        case (state_reg)
            S_CMP:   rd_addr = mid_next[AW-1:0];
            S_SH_RD: rd_addr = idx_dec[AW-1:0];
            default: rd_addr = mid_first[AW-1:0];
        endcase
        wr_en   = 1'b0;
        wr_addr = idx_reg[AW-1:0];
        wr_data = rd_data;
        if (state_reg == S_SH_WR)
        begin
            wr_en = 1'b1;
        end
        else if (state_reg == S_INS)
        begin
            wr_en   = 1'b1;
            wr_addr = lo_reg[AW-1:0];
            wr_data = id_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            lo_reg     <= '0;
            hi_reg     <= '0;
            mid_reg    <= '0;
            idx_reg    <= '0;
            op_reg     <= ACT_LOAD;
            id_reg     <= '0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg  <= cmd.action;
                        id_reg  <= cmd.id_value;
                        lo_reg  <= '0;
                        hi_reg  <= count_reg;
                        mid_reg <= mid_first;
                        case (cmd.action)
                            ACT_LOAD:
                            begin
                                if (count_reg >= CW'(CAPACITY))
                                begin
                                    done_reg   <= 1'b1;
                                    result_reg <= '{found: 1'b0, status: 1'b1,
                                                    entry_count: fit_count(count_reg)};
                                end
                                else if (count_reg == '0)
                                    state_reg <= S_INS;
                                else
                                    state_reg <= S_CMP;
                            end
                            ACT_QUERY:
                            begin
                                if (count_reg == '0)
                                begin
                                    done_reg   <= 1'b1;
                                    result_reg <= '{found: 1'b0, status: 1'b0,
                                                    entry_count: fit_count(count_reg)};
                                end
                                else
                                    state_reg <= S_CMP;
                            end
                            ACT_CLEAR:
                            begin
                                count_reg  <= '0;
                                done_reg   <= 1'b1;
                                result_reg <= '{found: 1'b0, status: 1'b0,
                                                entry_count: '0};
                            end
                            default:
                            begin
                                done_reg   <= 1'b1;
                                result_reg <= '{found: 1'b0, status: 1'b0,
                                                entry_count: fit_count(count_reg)};
                            end
                        endcase
                    end
                end
                S_CMP:
                begin
                    lo_reg  <= lo_next;
                    hi_reg  <= hi_next;
                    mid_reg <= mid_next;
                    if (op_reg == ACT_QUERY && cmp.eq)
                    begin
                        state_reg  <= S_IDLE;
                        done_reg   <= 1'b1;
                        result_reg <= '{found: 1'b1, status: 1'b0,
                                        entry_count: fit_count(count_reg)};
                    end
                    else if (lo_next >= hi_next)
                    begin
                        if (op_reg == ACT_QUERY)
                        begin
                            state_reg  <= S_IDLE;
                            done_reg   <= 1'b1;
                            result_reg <= '{found: 1'b0, status: 1'b0,
                                            entry_count: fit_count(count_reg)};
                        end
                        else
                        begin
                            // Open a slot at the insert point: move the tail up
                            idx_reg <= count_reg;
                            if (count_reg > lo_next)
                                state_reg <= S_SH_RD;
                            else
                                state_reg <= S_INS;
                        end
                    end
                end
                S_SH_RD:
                begin
                    state_reg <= S_SH_WR;
                end
                S_SH_WR:
                begin
                    idx_reg <= idx_dec;
                    if (idx_dec > lo_reg)
                        state_reg <= S_SH_RD;
                    else
                        state_reg <= S_INS;
                end
                S_INS:
                begin
                    count_reg  <= count_reg + CW'(1);
                    state_reg  <= S_IDLE;
                    done_reg   <= 1'b1;
                    result_reg <= '{found: 1'b0, status: 1'b0,
                                    entry_count: fit_count(count_reg + CW'(1))};
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

@@ verif/sid_scoreboard_pkg.sv @@
`timescale 1ns / 1ps
// Scoreboard for the sorted ID set membership unit: a sorted copy of the ID
// table and the queue of results that accepted items should produce.
// Depends on sid_pkg for the item types and action codes.

package sid_scoreboard_pkg;

    import sid_pkg::*;

    localparam int         SET_CAPACITY = 1024;
    localparam logic [1:0] ACT_UNUSED   = 2'd3;
    localparam int         MAX_PRINTED  = 40;

    class id_set_scoreboard;

        bit signed [ID_W-1:0] held_ids [SET_CAPACITY];
        int                   n_held;
        out_item_t            result_q [$];
        int                   n_errors;

        function new();
            n_held   = 0;
            n_errors = 0;
        endfunction

        function int pending();
            return result_q.size();
        endfunction

        function int held_count();
            return n_held;
        endfunction

        function bit signed [ID_W-1:0] held_at(input int idx);
            return held_ids[idx];
        endfunction

        // First index whose held ID is above id_value (signed order)
        function int upper_index(input bit signed [ID_W-1:0] id_value);
            int lo;
            int hi;
            int mid;
            lo = 0;
            hi = n_held;
            while (lo < hi)
            begin
                mid = (lo + hi) / 2;
                if (held_ids[mid] <= id_value)
                    lo = mid + 1;
                else
                    hi = mid;
            end
            return lo;
        endfunction

        function void note_input(input in_item_t item);
            out_item_t want;
            int        pos;
            want = '0;
            case (item.action)
                ACT_LOAD:
                begin
                    if (n_held >= SET_CAPACITY)
                        want.status = 1'b1;
                    else
                    begin
                        // insert after any equal entries
                        pos = upper_index(item.id_value);
                        for (int i = n_held; i > pos; i--)
                            held_ids[i] = held_ids[i-1];
                        held_ids[pos] = item.id_value;
                        n_held++;
                    end
                end
                ACT_QUERY:
                begin
                    pos = upper_index(item.id_value);
                    want.found = (pos > 0) && (held_ids[pos-1] == item.id_value);
                end
                ACT_CLEAR:
                    n_held = 0;
                default:
                    ;
            endcase
            want.entry_count = COUNT_W'(n_held);
            result_q.push_back(want);
        endfunction

        task report(input string what);
            n_errors++;
            if (n_errors <= MAX_PRINTED)
                $display("MISMATCH at %0t: %s", $time, what);
        endtask

        task check_result(input out_item_t got);
            out_item_t want;
            if (result_q.size() == 0)
            begin
                report($sformatf("result with no item pending: %p", got));
                return;
            end
            want = result_q.pop_front();
            if (got.found !== want.found)
                report($sformatf("found %b, want %b", got.found, want.found));
            if (got.status !== want.status)
                report($sformatf("status %b, want %b", got.status, want.status));
            if (got.entry_count !== want.entry_count)
                report($sformatf("entry_count %0d, want %0d",
                                 got.entry_count, want.entry_count));
        endtask

    endclass

endpackage

@@ verif/sorted_id_set_membership_unit_tb.sv @@
`timescale 1ns / 1ps
// Testbench for sorted_id_set_membership_unit: directed and random load,
// query and clear items checked against the scoreboard in sid_scoreboard_pkg.
// Depends on sid_pkg and sid_scoreboard_pkg.

module sorted_id_set_membership_unit_tb;

    import sid_pkg::*;
    import sid_scoreboard_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 50;
    localparam int PHASE_ITEMS    = 160;

    localparam logic signed [ID_W-1:0] ID_MIN = {1'b1, {(ID_W-1){1'b0}}};
    localparam logic signed [ID_W-1:0] ID_MAX = {1'b0, {(ID_W-1){1'b1}}};

    logic      clk   = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    in_item_t  cmd   = '0;
    logic      busy;
    logic      done;
    out_item_t result;

    id_set_scoreboard id_board;
    int               send_idle_pct = 0;
    int               items_sent    = 0;
    int               stall_cycles;

    sorted_id_set_membership_unit #(
        .CAPACITY(SET_CAPACITY)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd(cmd),
        .done(done),
        .result(result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Check results before noting a new item accepted at the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                id_board.check_result(result);
            if (start && !busy)
                id_board.note_input(cmd);
        end
    end

    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (start && !busy) || done)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    task automatic send_item(input logic [1:0] action,
                             input logic signed [ID_W-1:0] id_value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            start <= 1'b0;
            cmd   <= '{action: 2'($urandom_range(3)), id_value: ID_W'($urandom)};
            @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= '{action: action, id_value: id_value};
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
    endtask

    // Hold off until every pending result has come back
    task automatic wait_all_results();
        start <= 1'b0;
        @(posedge clk);
        while (id_board.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [ID_W-1:0] fresh_id(input int pool);
        logic signed [ID_W-1:0] id_value;
        case (pool)
            0:       id_value = $signed($urandom_range(15)) - 8;
            1:       id_value = $urandom;
            default:
            begin
                case ($urandom_range(6))
                    0:       id_value = ID_MIN;
                    1:       id_value = ID_MAX;
                    2:       id_value = ID_MIN + 1;
                    3:       id_value = ID_MAX - 1;
                    4:       id_value = '0;
                    5:       id_value = '1;
                    default: id_value = $urandom;
                endcase
            end
        endcase
        return id_value;
    endfunction

    // Mostly held IDs and their neighbors, so hits and near misses both occur
    function automatic logic signed [ID_W-1:0] query_id(input int pool);
        int                     n_now;
        logic signed [ID_W-1:0] id_value;
        n_now = id_board.held_count();
        if (n_now == 0 || $urandom_range(9) < 3)
            return fresh_id(pool);
        id_value = id_board.held_at($urandom_range(n_now - 1));
        case ($urandom_range(3))
            0:       id_value = id_value + 1;
            1:       id_value = id_value - 1;
            default: ;
        endcase
        return id_value;
    endfunction

    task automatic run_set_sequence(input int n_items);
        int pool;
        int roll;
        pool = $urandom_range(2);
        if ($urandom_range(9) != 0)
            send_item(ACT_CLEAR, $urandom);
        for (int k = 0; k < n_items; k++)
        begin
            roll = $urandom_range(99);
            if (roll < 55)
                send_item(ACT_LOAD, fresh_id(pool));
            else if (roll < 93)
                send_item(ACT_QUERY, query_id(pool));
            else if (roll < 97)
                send_item(ACT_UNUSED, $urandom);
            else
                send_item(ACT_CLEAR, $urandom);
        end
    endtask

    // Ascending loads keep each insert cheap; a few random ones land anywhere
    task automatic fill_to_capacity();
        longint next_id;
        send_item(ACT_CLEAR, $urandom);
        next_id = -(64'sd1 <<< 31) + longint'($urandom_range(1000));
        for (int k = 0; k < SET_CAPACITY - 4; k++)
        begin
            send_item(ACT_LOAD, next_id[ID_W-1:0]);
            next_id += longint'($urandom_range(2097151));
            if ($urandom_range(63) == 0)
                send_item(ACT_QUERY, query_id(1));
        end
        for (int k = 0; k < 4; k++)
            send_item(ACT_LOAD, $urandom);
        for (int k = 0; k < 8; k++)
            send_item(ACT_LOAD, fresh_id(2));
        for (int k = 0; k < 24; k++)
            send_item(ACT_QUERY, query_id(1));
        send_item(ACT_UNUSED, $urandom);
        send_item(ACT_CLEAR, $urandom);
    endtask

    initial
    begin
        int phase_start;
        id_board = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, extremes, duplicates, unused code, clear
        send_item(ACT_QUERY, '0);
        send_item(ACT_UNUSED, ID_MAX);
        send_item(ACT_LOAD, ID_MAX);
        send_item(ACT_LOAD, ID_MIN);
        send_item(ACT_LOAD, '0);
        send_item(ACT_LOAD, -32'sd1);
        send_item(ACT_LOAD, 32'sd5);
        send_item(ACT_LOAD, 32'sd5);
        send_item(ACT_QUERY, ID_MAX);
        send_item(ACT_QUERY, ID_MIN);
        send_item(ACT_QUERY, '0);
        send_item(ACT_QUERY, -32'sd1);
        send_item(ACT_QUERY, 32'sd5);
        send_item(ACT_QUERY, 32'sd6);
        send_item(ACT_QUERY, ID_MAX - 1);
        send_item(ACT_QUERY, ID_MIN + 1);
        send_item(ACT_UNUSED, ID_MIN);
        send_item(ACT_QUERY, 32'sd5);
        send_item(ACT_CLEAR, '1);
        send_item(ACT_QUERY, 32'sd5);
        send_item(ACT_LOAD, ID_MIN);
        send_item(ACT_QUERY, ID_MIN);
        send_item(ACT_CLEAR, '0);
        wait_all_results();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 59 : 0;
            if (phase == 0)
            begin
                fill_to_capacity();
                wait_all_results();
            end
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                if ($urandom_range(11) == 0)
                    run_set_sequence($urandom_range(100, 250));
                else
                    run_set_sequence($urandom_range(4, 30));
                if ($urandom_range(2) == 0)
                    wait_all_results();
            end
        end

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (id_board.n_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/sid_pkg.sv
rtl/sid_ram.sv
rtl/sid_cmp.sv
rtl/sorted_id_set_membership_unit.sv
verif/sid_scoreboard_pkg.sv
verif/sorted_id_set_membership_unit_tb.sv
